@@ rtl/bsne_pkg.sv @@
// ----------------------------------------------------------------------------
// bsne_pkg
// Shared types and constants for the b-spline stencil node enumerator.
// ----------------------------------------------------------------------------
package bsne_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SIZE_W     = 9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd6;

	// axis selection codes for the shared scaling unit
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// reset values of the configuration registers
	localparam logic [31:0]       INV_CELL_RST = 32'd65536;
	localparam logic [SIZE_W-1:0] SIZE_RST     = 9'd256;

	// stencil corner sits one cell below the particle cell
	localparam logic signed [33:0] CORNER_BACK = 34'sd1;

	// input transaction: particle position, signed q16.16
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_t;

	// output transaction: one in-range stencil node
	typedef struct packed {
		logic [7:0]  node_i;
		logic [7:0]  node_j;
		logic [7:0]  node_k;
		logic [23:0] node_address;
		logic        last_node;
	} out_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       issue;
		logic [1:0] axis;
		logic       span_en;
		logic       base1_en;
		logic       base2_en;
		logic       emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic empty;
		logic fire;
		logic last;
	} sts_t;

endpackage

@@ rtl/bspline_stencil_node_enumerator_core.sv @@
// ----------------------------------------------------------------------------
// bspline_stencil_node_enumerator_core
// Cubic b-spline stencil node enumerator for a particle-grid transfer.
// ----------------------------------------------------------------------------
// Usage: the in channel takes one particle position per transaction (signed
// q16.16 per axis). The out channel gives one transaction per grid node of
// the 4x4x4 stencil that lies inside the configured grid, walked with x
// outermost and z innermost; last_node marks the final node of a position.
// A position with no node inside the grid gives no output at all.
// The configuration port writes origin, reciprocal cell size and grid sizes
// one register per cycle; write it only while the block is idle.
// After a position is accepted, the shared scaling multiplier scales its
// three axes in turn, the stencil span is found and the address bases are
// set up (BASE1, BASE2); then one node per cycle leaves the output register
// while the receiver is ready. The next position is taken once the last
// node of the previous one is in the output register.
// Reset clears the controller and output valid and loads the register
// defaults. When the receiver stalls the node walk holds in place.
// ----------------------------------------------------------------------------
module bspline_stencil_node_enumerator_core #(
	parameter int MAX_DIM       = 256,
	parameter int STENCIL_WIDTH = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bsne_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bsne_pkg::out_t                  out_data,
	input  logic                            cfg_write,
	input  logic [bsne_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsne_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [31:0]                 origin_x_q, origin_y_q, origin_z_q, inv_cell_q;
	logic [bsne_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			inv_cell_q <= bsne_pkg::INV_CELL_RST;
			size_x_q   <= bsne_pkg::SIZE_RST;
			size_y_q   <= bsne_pkg::SIZE_RST;
			size_z_q   <= bsne_pkg::SIZE_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bsne_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data[31:0];
				bsne_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data[31:0];
				bsne_pkg::CFG_ORIGIN_Z: origin_z_q <= cfg_data[31:0];
				bsne_pkg::CFG_INV_CELL: inv_cell_q <= cfg_data[31:0];
				bsne_pkg::CFG_SIZE_X:   size_x_q   <= cfg_data[bsne_pkg::SIZE_W-1:0];
				bsne_pkg::CFG_SIZE_Y:   size_y_q   <= cfg_data[bsne_pkg::SIZE_W-1:0];
				bsne_pkg::CFG_SIZE_Z:   size_z_q   <= cfg_data[bsne_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	bsne_pkg::cmd_t cmd;
	bsne_pkg::sts_t sts;

	// controller
	bsne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	bsne_datapath #(
		.MAX_DIM       (MAX_DIM),
		.STENCIL_WIDTH (STENCIL_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_data       (in_data),
		.origin_x      (origin_x_q),
		.origin_y      (origin_y_q),
		.origin_z      (origin_z_q),
		.inv_cell_size (inv_cell_q),
		.size_x        (size_x_q),
		.size_y        (size_y_q),
		.size_z        (size_z_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

endmodule

@@ rtl/bsne_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsne_ctrl
// Sequencer: scale three axes, find the stencil span, then walk the nodes.
// ----------------------------------------------------------------------------
module bsne_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bsne_pkg::sts_t  sts,
	output bsne_pkg::cmd_t  cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL   = 6'b000010,
		ST_SPAN  = 6'b000100,
		ST_BASE1 = 6'b001000,
		ST_BASE2 = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	// x issued at count 0, z corner lands at the end of count 4
	localparam logic [2:0] MUL_ISSUES = 3'd3;
	localparam logic [2:0] MUL_LAST   = 3'd4;

	state_t     state_q, state_d;
	logic [2:0] cnt_q;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_MUL;
			ST_MUL:   if (cnt_q == MUL_LAST) state_d = ST_SPAN;
			ST_SPAN:  state_d = ST_BASE1;
			ST_BASE1: state_d = sts.empty ? ST_IDLE : ST_BASE2;
			ST_BASE2: state_d = ST_EMIT;
			ST_EMIT:  if (sts.fire && sts.last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// state and issue counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) cnt_q <= cnt_q + 3'd1;
			else cnt_q <= '0;
		end
	end

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.issue    = (state_q == ST_MUL) && (cnt_q < MUL_ISSUES);
		cmd.axis     = cnt_q[1:0];
		cmd.span_en  = (state_q == ST_SPAN);
		cmd.base1_en = (state_q == ST_BASE1);
		cmd.base2_en = (state_q == ST_BASE2);
		cmd.emit     = (state_q == ST_EMIT);
	end

endmodule

@@ rtl/bsne_datapath.sv @@
// ----------------------------------------------------------------------------
// bsne_datapath
// Position scaling, stencil span per axis, node walk and output register.
// ----------------------------------------------------------------------------
module bsne_datapath #(
	parameter int MAX_DIM       = 256,
	parameter int STENCIL_WIDTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bsne_pkg::cmd_t              cmd,
	output bsne_pkg::sts_t              sts,
	input  bsne_pkg::in_t               in_data,
	input  logic [31:0]                 origin_x,
	input  logic [31:0]                 origin_y,
	input  logic [31:0]                 origin_z,
	input  logic [31:0]                 inv_cell_size,
	input  logic [bsne_pkg::SIZE_W-1:0] size_x,
	input  logic [bsne_pkg::SIZE_W-1:0] size_y,
	input  logic [bsne_pkg::SIZE_W-1:0] size_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bsne_pkg::out_t              out_data
);

	localparam int OFS_W = (STENCIL_WIDTH > 2) ? $clog2(STENCIL_WIDTH) : 1;
	localparam int SW    = bsne_pkg::SIZE_W;
	localparam logic [10:0]        MAX_DIM_L = 11'(MAX_DIM);
	localparam logic signed [33:0] CLAMP_LO  = -34'sd8;
	localparam logic signed [33:0] CLAMP_HI  = 34'sd1000;

	typedef struct packed {
		logic [OFS_W-1:0] lo;
		logic [OFS_W-1:0] hi;
		logic             none;
	} span_t;

	// range of stencil offsets whose node lies inside [0, size)
	function automatic span_t axis_span(input logic [10:0] corner, input logic [SW-1:0] size);
		span_t      s;
		logic [11:0] n;
		logic        hit;
		s   = '0;
		hit = 1'b0;
		for (int o = STENCIL_WIDTH - 1; o >= 0; o--) begin
			n = {corner[10], corner} + 12'(o);
			if (!n[11] && (n[10:0] < {2'b00, size})) s.lo = OFS_W'(o);
		end
		for (int o = 0; o < STENCIL_WIDTH; o++) begin
			n = {corner[10], corner} + 12'(o);
			if (!n[11] && (n[10:0] < {2'b00, size})) begin
				s.hi = OFS_W'(o);
				hit  = 1'b1;
			end
		end
		s.none = !hit;
		return s;
	endfunction

	// effective sizes, clamped to the grid limit
	logic [SW-1:0] eff_x, eff_y, eff_z;
	assign eff_x = ({2'b00, size_x} > MAX_DIM_L) ? MAX_DIM_L[SW-1:0] : size_x;
	assign eff_y = ({2'b00, size_y} > MAX_DIM_L) ? MAX_DIM_L[SW-1:0] : size_y;
	assign eff_z = ({2'b00, size_z} > MAX_DIM_L) ? MAX_DIM_L[SW-1:0] : size_z;

	// plane stride, only follows configuration
	logic [2*SW-1:0] syz_q;
	always_ff @(posedge clk) begin
		syz_q <= eff_y * eff_z;
	end

	// latched position
	bsne_pkg::in_t pos_q;
	always_ff @(posedge clk) begin
		if (cmd.load) pos_q <= in_data;
	end

	// stage 1: relative offset magnitude
	logic [31:0] pos_sel, org_sel;
	logic [32:0] rel, mag;
	always_comb begin
		case (cmd.axis)
			bsne_pkg::AXIS_X: begin
				pos_sel = pos_q.pos_x;
				org_sel = origin_x;
			end
			bsne_pkg::AXIS_Y: begin
				pos_sel = pos_q.pos_y;
				org_sel = origin_y;
			end
			default: begin
				pos_sel = pos_q.pos_z;
				org_sel = origin_z;
			end
		endcase
		rel = {pos_sel[31], pos_sel} - {org_sel[31], org_sel};
		mag = rel[32] ? (33'd0 - rel) : rel;
	end

	logic [31:0] mag_s1;
	logic        neg_s1, vld_s1;
	logic [1:0]  axis_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= cmd.issue;
	end
	always_ff @(posedge clk) begin
		mag_s1  <= mag[31:0];
		neg_s1  <= rel[32];
		axis_s1 <= cmd.axis;
	end

	// stage 2: scale by the reciprocal cell size
	logic [63:0] prod_s2;
	logic        neg_s2, vld_s2;
	logic [1:0]  axis_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		prod_s2 <= mag_s1 * inv_cell_size;
		neg_s2  <= neg_s1;
		axis_s2 <= axis_s1;
	end

	// stage 3: floor, step back one cell and clamp to a narrow range
	logic [33:0] q_up, cell_idx, corner;
	logic [10:0] corner_c;
	always_comb begin
		q_up = {2'b00, prod_s2[63:32]} + {33'd0, |prod_s2[31:0]};
		cell_idx = neg_s2 ? (34'd0 - q_up) : {2'b00, prod_s2[63:32]};
		corner = cell_idx - CORNER_BACK_L;
		if ($signed(corner) < CLAMP_LO) corner_c = CLAMP_LO[10:0];
		else if ($signed(corner) > CLAMP_HI) corner_c = CLAMP_HI[10:0];
		else corner_c = corner[10:0];
	end

	logic [10:0] cx_q, cy_q, cz_q;
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			case (axis_s2)
				bsne_pkg::AXIS_X: cx_q <= corner_c;
				bsne_pkg::AXIS_Y: cy_q <= corner_c;
				default:          cz_q <= corner_c;
			endcase
		end
	end

	// stencil span per axis
	span_t sx_q, sy_q, sz_q;
	logic  empty_q;
	span_t sx_d, sy_d, sz_d;
	assign sx_d = axis_span(cx_q, eff_x);
	assign sy_d = axis_span(cy_q, eff_y);
	assign sz_d = axis_span(cz_q, eff_z);
	always_ff @(posedge clk) begin
		if (cmd.span_en) begin
			sx_q    <= sx_d;
			sy_q    <= sy_d;
			sz_q    <= sz_d;
			empty_q <= sx_d.none || sy_d.none || sz_d.none;
		end
	end

	// walk counters and current node coordinates
	logic [OFS_W-1:0] a_q, b_q, c_q;
	logic [11:0]      ni, nj, nk, ni_lo, nj_lo;
	assign ni    = {cx_q[10], cx_q} + 12'(a_q);
	assign nj    = {cy_q[10], cy_q} + 12'(b_q);
	assign nk    = {cz_q[10], cz_q} + 12'(c_q);
	assign ni_lo = {cx_q[10], cx_q} + 12'(sx_q.lo);
	assign nj_lo = {cy_q[10], cy_q} + 12'(sy_q.lo);

	// address bases: plane base, row base and first row offset
	logic [23:0]     ai_q, bj_q;
	logic [2*SW-1:0] jb0_q;
	logic [3*SW-1:0] ai_prod;
	assign ai_prod = ni_lo[SW-1:0] * syz_q;

	logic last, fire;
	assign last = (a_q == sx_q.hi) && (b_q == sy_q.hi) && (c_q == sz_q.hi);
	assign fire = cmd.emit && (!out_valid || out_ready);

	always_ff @(posedge clk) begin
		if (cmd.base1_en) begin
			a_q   <= sx_q.lo;
			b_q   <= sy_q.lo;
			c_q   <= sz_q.lo;
			ai_q  <= ai_prod[23:0];
			jb0_q <= nj_lo[SW-1:0] * eff_z;
		end else if (cmd.base2_en) begin
			bj_q <= ai_q + 24'(jb0_q);
		end else if (fire) begin
			if (c_q != sz_q.hi) begin
				c_q <= c_q + OFS_W'(1);
			end else if (b_q != sy_q.hi) begin
				b_q  <= b_q + OFS_W'(1);
				c_q  <= sz_q.lo;
				bj_q <= bj_q + 24'(eff_z);
			end else begin
				a_q  <= a_q + OFS_W'(1);
				b_q  <= sy_q.lo;
				c_q  <= sz_q.lo;
				ai_q <= ai_q + 24'(syz_q);
				bj_q <= ai_q + 24'(syz_q) + 24'(jb0_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (fire) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (fire) begin
			out_data.node_i       <= ni[7:0];
			out_data.node_j       <= nj[7:0];
			out_data.node_k       <= nk[7:0];
			out_data.node_address <= bj_q + 24'(nk[SW-1:0]);
			out_data.last_node    <= last;
		end
	end

	assign sts.empty = empty_q;
	assign sts.fire  = fire;
	assign sts.last  = last;

	// corner step back, taken from the package
	localparam logic [33:0] CORNER_BACK_L = bsne_pkg::CORNER_BACK;

endmodule

@@ sim/bspline_stencil_node_enumerator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_stencil_node_enumerator_core_tb
// Self-checking bench for the cubic b-spline stencil node enumerator.
// ----------------------------------------------------------------------------
// Particle positions go in on a valid/ready channel fed from a queue, and a
// scoreboard predicts every in-range stencil node of each accepted position
// from its own copy of the grid registers. Nodes leaving the block are
// checked field by field against the oldest predicted node. Directed
// positions hit the field extremes and grid corner cases, then random phases
// reprogram the grid and send mostly positions that land near the grid,
// with some raw noise. Both channels stall at random save in one phase.
// ----------------------------------------------------------------------------
module bspline_stencil_node_enumerator_core_tb;

	localparam int GRID_MAX      = 256;
	localparam int STENCIL       = 4;
	localparam int SETTLE        = 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 53;
	localparam logic [bsne_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                            clk;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	bsne_pkg::in_t                   in_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	bsne_pkg::out_t                  out_data;
	logic                            cfg_write = 1'b0;
	logic [bsne_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bsne_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// bench copy of the grid registers
	logic [31:0]                 org_x = '0;
	logic [31:0]                 org_y = '0;
	logic [31:0]                 org_z = '0;
	logic [31:0]                 inv_scale = bsne_pkg::INV_CELL_RST;
	logic [bsne_pkg::SIZE_W-1:0] dim_x = bsne_pkg::SIZE_RST;
	logic [bsne_pkg::SIZE_W-1:0] dim_y = bsne_pkg::SIZE_RST;
	logic [bsne_pkg::SIZE_W-1:0] dim_z = bsne_pkg::SIZE_RST;

	bsne_pkg::in_t  pos_q[$];
	bsne_pkg::out_t node_q[$];
	bsne_pkg::out_t want;
	int   err_count = 0;
	int   quiet_cycles = 0;
	int   send_gap_pct = 36;
	int   recv_gap_pct = 36;

	bspline_stencil_node_enumerator_core #(
		.MAX_DIM       (GRID_MAX),
		.STENCIL_WIDTH (STENCIL)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// grid size clamped to the largest supported dimension
	function automatic int grid_extent(logic [bsne_pkg::SIZE_W-1:0] dim);
		return (dim > GRID_MAX) ? GRID_MAX : int'(dim);
	endfunction

	// floor((pos - org) * inv / 2^32) minus one, exact in wide signed math
	function automatic longint stencil_corner(logic [31:0] pos, logic [31:0] org);
		logic signed [32:0] rel;
		logic signed [65:0] prod;
		logic signed [65:0] cell_idx;
		rel      = $signed({pos[31], pos}) - $signed({org[31], org});
		prod     = rel * $signed({1'b0, inv_scale});
		cell_idx = prod >>> 32;
		return longint'(cell_idx) - longint'(bsne_pkg::CORNER_BACK);
	endfunction

	// walk the 4x4x4 stencil, x outermost, and queue every in-range node
	function automatic void enumerate_nodes(bsne_pkg::in_t p);
		longint         cx, cy, cz, i, j, k, addr;
		int             sx, sy, sz, ox, oy, oz;
		bsne_pkg::out_t node, held;
		bit             have;
		cx = stencil_corner(p.pos_x, org_x);
		cy = stencil_corner(p.pos_y, org_y);
		cz = stencil_corner(p.pos_z, org_z);
		sx = grid_extent(dim_x);
		sy = grid_extent(dim_y);
		sz = grid_extent(dim_z);
		have = 1'b0;
		held = '0;
		for (ox = 0; ox < STENCIL; ox++) begin
			i = cx + ox;
			if (i < 0 || i >= sx) continue;
			for (oy = 0; oy < STENCIL; oy++) begin
				j = cy + oy;
				if (j < 0 || j >= sy) continue;
				for (oz = 0; oz < STENCIL; oz++) begin
					k = cz + oz;
					if (k < 0 || k >= sz) continue;
					addr = i * sy * sz + j * sz + k;
					node.node_i       = i[7:0];
					node.node_j       = j[7:0];
					node.node_k       = k[7:0];
					node.node_address = addr[23:0];
					node.last_node    = 1'b0;
					if (have) node_q = {node_q, held};
					held = node;
					have = 1'b1;
				end
			end
		end
		// final node of the position carries the last flag
		if (have) begin
			held.last_node = 1'b1;
			node_q = {node_q, held};
		end
	endfunction

	// coordinate whose cell falls a few cells around the grid on one axis
	function automatic logic [31:0] pos_near(logic [31:0] org,
			logic [bsne_pkg::SIZE_W-1:0] dim);
		longint cells, rel, p;
		if (inv_scale == 0) return $urandom;
		cells = longint'($urandom_range(grid_extent(dim) + 4)) - 3;
		rel   = ((cells <<< 32) + longint'($urandom)) / longint'(inv_scale);
		p     = longint'($signed(org)) + rel;
		if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
		return p[31:0];
	endfunction

	function automatic logic [31:0] pick_origin();
		logic [31:0] o;
		if ($urandom_range(3) == 0) return $urandom;
		o = $urandom_range(33554431);
		return o - 32'd16777216;
	endfunction

	function automatic logic [31:0] pick_dim();
		case ($urandom_range(7))
			0: return 32'd1;
			1: return 32'd256;
			2: return 32'($urandom_range(257, 511));
			default: return 32'($urandom_range(1, 256));
		endcase
	endfunction

	task automatic add_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bsne_pkg::in_t p;
		p.pos_x = x;
		p.pos_y = y;
		p.pos_z = z;
		pos_q = {pos_q, p};
	endtask

	// register write, mirrored into the bench copy
	task automatic write_reg(logic [bsne_pkg::CFG_IDX_W-1:0] idx,
			logic [bsne_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			bsne_pkg::CFG_ORIGIN_X: org_x = data;
			bsne_pkg::CFG_ORIGIN_Y: org_y = data;
			bsne_pkg::CFG_ORIGIN_Z: org_z = data;
			bsne_pkg::CFG_INV_CELL: inv_scale = data;
			bsne_pkg::CFG_SIZE_X:   dim_x = data[bsne_pkg::SIZE_W-1:0];
			bsne_pkg::CFG_SIZE_Y:   dim_y = data[bsne_pkg::SIZE_W-1:0];
			bsne_pkg::CFG_SIZE_Z:   dim_z = data[bsne_pkg::SIZE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// hold off until every position is sent and every node has come back
	task automatic settle();
		@(negedge clk);
		while (pos_q.size() != 0 || in_valid || node_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// position driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
		end else if (!in_valid || in_ready) begin
			if (pos_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				in_valid <= 1'b1;
				in_data  <= pos_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// node receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// check each node transaction, then predict for each position transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (node_q.size() == 0) begin
					$error("unexpected node: i %0d j %0d k %0d address %0d",
						out_data.node_i, out_data.node_j, out_data.node_k,
						out_data.node_address);
					err_count++;
				end else begin
					want = node_q.pop_front();
					if (out_data.node_i !== want.node_i) begin
						$error("node_i: expected %0d, got %0d", want.node_i, out_data.node_i);
						err_count++;
					end
					if (out_data.node_j !== want.node_j) begin
						$error("node_j: expected %0d, got %0d", want.node_j, out_data.node_j);
						err_count++;
					end
					if (out_data.node_k !== want.node_k) begin
						$error("node_k: expected %0d, got %0d", want.node_k, out_data.node_k);
						err_count++;
					end
					if (out_data.node_address !== want.node_address) begin
						$error("node_address: expected %0d, got %0d",
							want.node_address, out_data.node_address);
						err_count++;
					end
					if (out_data.last_node !== want.last_node) begin
						$error("last_node: expected %0d, got %0d",
							want.last_node, out_data.last_node);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready) enumerate_nodes(in_data);
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus sequence
	initial begin
		logic [31:0] inv_pick;
		int ph, n;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset grid: origin zero, unit cells, full size
		add_pos(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_pos(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		add_pos(32'h00FF_8000, 32'h00FF_8000, 32'h00FF_8000);
		add_pos(32'hFFFF_8000, 32'h0064_4000, 32'h0011_0000);
		add_pos(32'h000A_0000, 32'h0014_FFBE, 32'h001E_0000);
		add_pos(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
		settle();

		// extreme origins, largest reciprocal, single-node z axis
		write_reg(bsne_pkg::CFG_ORIGIN_X, 32'h8000_0000);
		write_reg(bsne_pkg::CFG_ORIGIN_Y, 32'h7FFF_FFFF);
		write_reg(bsne_pkg::CFG_ORIGIN_Z, 32'h0000_0000);
		write_reg(bsne_pkg::CFG_INV_CELL, 32'hFFFF_FFFF);
		write_reg(bsne_pkg::CFG_SIZE_X, 32'd256);
		write_reg(bsne_pkg::CFG_SIZE_Y, 32'd256);
		write_reg(bsne_pkg::CFG_SIZE_Z, 32'd1);
		@(negedge clk);
		add_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
		add_pos(32'h8000_0010, 32'h7FFF_FFFE, 32'hFFFF_FFFF);
		add_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		settle();

		// zero size on x leaves nothing in range
		write_reg(bsne_pkg::CFG_ORIGIN_X, 32'h0000_0000);
		write_reg(bsne_pkg::CFG_ORIGIN_Y, 32'h0000_0000);
		write_reg(bsne_pkg::CFG_INV_CELL, bsne_pkg::INV_CELL_RST);
		write_reg(bsne_pkg::CFG_SIZE_X, 32'd0);
		write_reg(bsne_pkg::CFG_SIZE_Z, 32'(bsne_pkg::SIZE_RST));
		@(negedge clk);
		add_pos(32'h0005_0000, 32'h0005_0000, 32'h0005_0000);
		settle();

		// sizes above the maximum clamp; unused index must not disturb anything
		write_reg(bsne_pkg::CFG_SIZE_X, 32'd511);
		write_reg(bsne_pkg::CFG_SIZE_Y, 32'd300);
		write_reg(CFG_UNUSED, 32'h0000_0000);
		@(negedge clk);
		add_pos(32'h00FE_0000, 32'h00FE_0000, 32'h0003_0000);
		add_pos(32'hFFFF_0000, 32'h00FF_0000, 32'h0000_0000);
		settle();

		// zero reciprocal puts every position at cell zero
		write_reg(bsne_pkg::CFG_INV_CELL, 32'h0000_0000);
		@(negedge clk);
		add_pos($urandom, $urandom, $urandom);
		add_pos($urandom, $urandom, $urandom);
		settle();

		// smallest reciprocal with origins at the negative extreme
		write_reg(bsne_pkg::CFG_ORIGIN_X, 32'h8000_0000);
		write_reg(bsne_pkg::CFG_ORIGIN_Y, 32'h8000_0000);
		write_reg(bsne_pkg::CFG_ORIGIN_Z, 32'h8000_0000);
		write_reg(bsne_pkg::CFG_INV_CELL, 32'h0000_0001);
		@(negedge clk);
		add_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_pos(32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		settle();

		// random grids, mostly positions near the grid plus raw noise
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			send_gap_pct = (ph == 2) ? 0 : 36;
			recv_gap_pct = (ph == 2) ? 0 : 36;
			case ($urandom_range(5))
				0: inv_pick = 32'd65536;
				1: inv_pick = 32'd131072;
				2: inv_pick = 32'd16384;
				3: inv_pick = 32'd1048576;
				4: inv_pick = $urandom_range(4096, 4194304);
				default: inv_pick = $urandom;
			endcase
			write_reg(bsne_pkg::CFG_ORIGIN_X, pick_origin());
			write_reg(bsne_pkg::CFG_ORIGIN_Y, pick_origin());
			write_reg(bsne_pkg::CFG_ORIGIN_Z, pick_origin());
			write_reg(bsne_pkg::CFG_INV_CELL, inv_pick);
			write_reg(bsne_pkg::CFG_SIZE_X, pick_dim());
			write_reg(bsne_pkg::CFG_SIZE_Y, pick_dim());
			write_reg(bsne_pkg::CFG_SIZE_Z, pick_dim());
			@(negedge clk);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < 85)
					add_pos(pos_near(org_x, dim_x), pos_near(org_y, dim_y),
						pos_near(org_z, dim_z));
				else
					add_pos($urandom, $urandom, $urandom);
			end
			settle();
		end

		if (node_q.size() != 0) begin
			$error("%0d predicted nodes never arrived", node_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bsne_pkg.sv
rtl/bsne_ctrl.sv
rtl/bsne_datapath.sv
rtl/bspline_stencil_node_enumerator_core.sv
sim/bspline_stencil_node_enumerator_core_tb.sv
